// File: hw/rtl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types and constants for the tilt direction classifier
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int unsigned AccelW = 16;
  localparam int unsigned LimitW = 15;
  localparam logic [LimitW-1:0] TiltLimitReset = 15'd300;

  typedef enum logic [2:0] {
    DIR_STABLE   = 3'd0,
    DIR_RIGHT    = 3'd1,
    DIR_LEFT     = 3'd2,
    DIR_FORWARD  = 3'd3,
    DIR_BACKWARD = 3'd4,
    DIR_UPSIDE   = 3'd5
  } dir_e;

  // one accelerometer sample
  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
  } accel_t;

  // one classification result
  typedef struct packed {
    dir_e direction;
    logic direction_entered;
  } result_t;

endpackage

// File: hw/rtl/tdc_cell.sv
// ----------------------------------------------------------------------------
// tdc_cell
// one window slot: holds a sample and passes it on at each shift
// ----------------------------------------------------------------------------
module tdc_cell import tdc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  accel_t sample_i,
  output accel_t sample_o
);

  accel_t sample_q, sample_d;

  always_comb begin
    sample_d = shift_i ? sample_i : sample_q;
  end

  // window starts out all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

// File: hw/rtl/tdc_accum.sv
// ----------------------------------------------------------------------------
// tdc_accum
// running window sums per axis and direction classification
// ----------------------------------------------------------------------------
module tdc_accum import tdc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  accel_t            sample_i,
  input  accel_t            oldest_i,
  input  logic [LimitW-1:0] tilt_limit_i,
  output result_t           result_o
);

  localparam int unsigned SumW = AccelW + $clog2(WINDOW_LEN);
  localparam int unsigned CmpW = SumW + 1;
  localparam int unsigned ExtW = SumW - AccelW;

  logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic signed [SumW-1:0] sum_x_d, sum_y_d, sum_z_d;
  dir_e                   prev_q, prev_d;

  logic [CmpW-1:0]        thr_u;
  logic signed [CmpW-1:0] thr_pos, thr_neg;
  logic signed [CmpW-1:0] sx, sy;
  dir_e                   dir, cls;
  logic                   entered;

  // new sum = old sum + incoming sample - sample leaving the window
  always_comb begin
    sum_x_d = sum_x_q + {{ExtW{sample_i.accel_x[AccelW-1]}}, sample_i.accel_x}
                      - {{ExtW{oldest_i.accel_x[AccelW-1]}}, oldest_i.accel_x};
    sum_y_d = sum_y_q + {{ExtW{sample_i.accel_y[AccelW-1]}}, sample_i.accel_y}
                      - {{ExtW{oldest_i.accel_y[AccelW-1]}}, oldest_i.accel_y};
    sum_z_d = sum_z_q + {{ExtW{sample_i.accel_z[AccelW-1]}}, sample_i.accel_z}
                      - {{ExtW{oldest_i.accel_z[AccelW-1]}}, oldest_i.accel_z};
  end

  // mean limit scaled by window length, compared against sums
  assign thr_u   = CmpW'(tilt_limit_i) * CmpW'(WINDOW_LEN);
  assign thr_pos = signed'(thr_u);
  assign thr_neg = -thr_pos;
  assign sx      = signed'({sum_x_d[SumW-1], sum_x_d});
  assign sy      = signed'({sum_y_d[SumW-1], sum_y_d});

  always_comb begin
    if (sx < thr_neg && sx < sy) begin
      dir = DIR_RIGHT;
    end else if (sx > thr_pos && sx > sy) begin
      dir = DIR_LEFT;
    end else if (sy < thr_neg && sx >= sy) begin
      dir = DIR_FORWARD;
    end else if (sy > thr_pos && sx <= sy) begin
      dir = DIR_BACKWARD;
    end else if (sum_z_d[SumW-1]) begin
      dir = DIR_UPSIDE;
    end else begin
      dir = DIR_STABLE;
    end
  end

  // upside down shares the stable class
  always_comb begin
    case (dir)
      DIR_RIGHT, DIR_LEFT, DIR_FORWARD, DIR_BACKWARD: cls = dir;
      default:                                        cls = DIR_STABLE;
    endcase
    entered = (cls != DIR_STABLE) && (cls != prev_q);
    prev_d  = en_i ? cls : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      prev_q  <= DIR_STABLE;
    end else begin
      if (en_i) begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        sum_z_q <= sum_z_d;
      end
      prev_q <= prev_d;
    end
  end

  assign result_o.direction         = dir;
  assign result_o.direction_entered = entered;

  // stored class never holds upside down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_q != DIR_UPSIDE)
    else $error("upside down stored as previous class");

  // entering a direction always reports a tilt class
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entered |-> (dir != DIR_STABLE && dir != DIR_UPSIDE))
    else $error("entered flag on non-tilt direction");

  // sums only move on an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(sum_x_q) && $stable(sum_y_q) && $stable(sum_z_q)))
    else $error("sums changed without a request");

endmodule

// File: hw/rtl/tilt_direction_classifier_top.sv
// ----------------------------------------------------------------------------
// tilt_direction_classifier_top
// moving-average tilt classifier over a window of accelerometer samples
// ----------------------------------------------------------------------------
// Each request carries one signed x/y/z accelerometer sample and yields one
// result: the tilt direction of the mean over the last WINDOW_LEN samples
// (stable, right, left, forward, backward, upside down) and a flag that is
// set when a new tilt direction is entered. The window is a chain of
// WINDOW_LEN cells that shift on every accepted request; the sample falling
// out of the last cell is subtracted from a per-axis running sum, and sums
// are compared against tilt_limit * WINDOW_LEN. At reset the window is all
// zero and those zeros count until the window has filled. One request is
// taken per clock cycle unless in_stall_o is high; sum update and compares
// are combinational and the result is registered. An output register plus
// one skid entry keep the input running while a result waits; in_stall_o
// is driven straight from the skid flag. The user must write tilt_limit
// through cfg_we_i/cfg_wdata_i while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tilt_direction_classifier_top import tdc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // sample requests
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  accel_t            in_item_i,
  // results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           out_item_o,
  // tilt_limit register
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  logic [LimitW-1:0] tilt_limit_q, tilt_limit_d;

  logic    out_valid_q, out_valid_d;
  result_t out_item_q, out_item_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_item_q, skid_item_d;

  logic    accept;
  logic    out_fire;
  result_t result;

  // tap 0 is the incoming sample, the last tap is the oldest in the window
  accel_t  tap [WINDOW_LEN+1];

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_fire   = out_valid_q & ~out_stall_i;

  assign tap[0] = in_item_i;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    tdc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (tap[i]),
      .sample_o (tap[i+1])
    );
  end

  tdc_accum #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .sample_i     (in_item_i),
    .oldest_i     (tap[WINDOW_LEN]),
    .tilt_limit_i (tilt_limit_q),
    .result_o     (result)
  );

  // config register
  always_comb begin
    tilt_limit_d = cfg_we_i ? cfg_wdata_i : tilt_limit_q;
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    skid_valid_d = skid_valid_q;
    skid_item_d  = skid_item_q;
    if (skid_valid_q && out_fire) begin
      // skid drains into the output, input is held meanwhile
      out_item_d   = skid_item_q;
      skid_valid_d = 1'b0;
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_item_d  = result;
      end else begin
        // output is held downstream, park the new result
        skid_valid_d = 1'b1;
        skid_item_d  = result;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_limit_q <= TiltLimitReset;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      tilt_limit_q <= tilt_limit_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a parked result always has an older one in front of it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output is empty");

  // skid only fills when the output was held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled while output was free");

  // an accepted request always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

endmodule
